[rtl/gstdf_pkg.sv]
// Shared types and codes for the generational slot table.
package gstdf_pkg;

    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_DESTROY = 2'd1;
    localparam logic [1:0] MODE_RESOLVE = 2'd2;
    localparam logic [1:0] MODE_TICK    = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_STALE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [3:0] FIF_RESET = 4'd2;
    localparam int         FRAME_W   = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOK,
        ST_EXEC,
        ST_TICK_RD,
        ST_TICK_WAIT,
        ST_TICK_DO,
        ST_TICK_GEN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic latch_req;
        logic look;
        logic exec;
        logic tick_start;
        logic tick_rd;
        logic tick_do;
        logic tick_gen;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_tick;
        logic scan_done;
        logic retire;
    } dp_stat_t;

endpackage

[rtl/gstdf_ram.sv]
// Generic RAM with one write port and one registered read port.
module gstdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gstdf_ctrl.sv]
// Controller state machine for the slot table.
module gstdf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  gstdf_pkg::dp_stat_t stat,
    output gstdf_pkg::dp_cmd_t  cmd
);

    gstdf_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gstdf_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == gstdf_pkg::ST_IDLE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gstdf_pkg::ST_CLEAR:     if (stat.clear_done) state_next = gstdf_pkg::ST_IDLE;
            gstdf_pkg::ST_IDLE:      if (in_valid && in_ready) state_next = gstdf_pkg::ST_LOOK;
            gstdf_pkg::ST_LOOK:
                state_next = stat.is_tick ? gstdf_pkg::ST_TICK_RD : gstdf_pkg::ST_EXEC;
            gstdf_pkg::ST_EXEC:      state_next = gstdf_pkg::ST_OUT;
            gstdf_pkg::ST_TICK_RD:
                state_next = stat.scan_done ? gstdf_pkg::ST_OUT : gstdf_pkg::ST_TICK_WAIT;
            gstdf_pkg::ST_TICK_WAIT: state_next = gstdf_pkg::ST_TICK_DO;
            gstdf_pkg::ST_TICK_DO:
                state_next = stat.retire ? gstdf_pkg::ST_TICK_GEN : gstdf_pkg::ST_TICK_RD;
            gstdf_pkg::ST_TICK_GEN:  state_next = gstdf_pkg::ST_TICK_RD;
            gstdf_pkg::ST_OUT:       state_next = gstdf_pkg::ST_IDLE;
            default:                 state_next = gstdf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            gstdf_pkg::ST_CLEAR:     cmd.clear_step = 1'b1;
            gstdf_pkg::ST_IDLE:      cmd.latch_req = in_valid && in_ready;
            gstdf_pkg::ST_LOOK:
            begin
                cmd.look       = 1'b1;
                cmd.tick_start = stat.is_tick;
            end
            gstdf_pkg::ST_EXEC:      cmd.exec = 1'b1;
            gstdf_pkg::ST_TICK_RD:   cmd.tick_rd = !stat.scan_done;
            gstdf_pkg::ST_TICK_WAIT: ;
            gstdf_pkg::ST_TICK_DO:   cmd.tick_do = 1'b1;
            gstdf_pkg::ST_TICK_GEN:  cmd.tick_gen = 1'b1;
            gstdf_pkg::ST_OUT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[rtl/gstdf_dp.sv]
// Datapath: slot memories, free stack, pending queue and counters.
module gstdf_dp #(
    parameter int SLOT_COUNT = 256,
    parameter int GEN_WIDTH  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gstdf_pkg::dp_cmd_t    cmd,
    output gstdf_pkg::dp_stat_t   stat,
    input  logic [1:0]            mode,
    input  logic [7:0]            slot_index,
    input  logic [15:0]           handle_generation,
    input  logic [3:0]            age_limit,
    output logic [1:0]            status,
    output logic [7:0]            out_index,
    output logic [15:0]           out_generation,
    output logic [8:0]            retired_count
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOT_COUNT);

    logic [1:0]           mode_reg;
    logic [7:0]           idx_in_reg;
    logic [15:0]          gen_in_reg;
    logic [CW-1:0]        high_reg, free_cnt_reg, pend_cnt_reg;
    logic [31:0]          frame_reg;
    logic [CW-1:0]        clr_reg;
    logic [CW-1:0]        rd_reg, keep_reg, ret_reg;
    logic [1:0]           st_reg;
    logic [IW-1:0]        oidx_reg;
    logic [GEN_WIDTH-1:0] ogen_reg;

    // slot state memory: {alive, generation}
    logic                   s_we;
    logic [IW-1:0]          s_waddr, s_raddr;
    logic [GEN_WIDTH:0]     s_wdata, s_rdata;
    logic                   f_we;
    logic [IW-1:0]          f_waddr, f_raddr;
    logic [IW-1:0]          f_wdata, f_rdata;
    logic                   p_we;
    logic [IW-1:0]          p_waddr, p_raddr;
    logic [IW+31:0]         p_wdata, p_rdata;

    gstdf_ram #(.WIDTH(GEN_WIDTH + 1), .DEPTH(SLOT_COUNT)) u_slot (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));
    gstdf_ram #(.WIDTH(IW), .DEPTH(SLOT_COUNT)) u_free (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));
    gstdf_ram #(.WIDTH(IW + 32), .DEPTH(SLOT_COUNT)) u_pend (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));

    logic         clearing;
    logic         idx_ok, live;
    logic [IW-1:0] in_idx;
    logic [IW-1:0] alloc_slot;
    logic [IW-1:0] pend_slot;
    logic [31:0]  pend_frame;
    logic         aged;

    assign clearing = cmd.clear_step;
    assign in_idx   = IW'(idx_in_reg);
    assign idx_ok   = ({24'd0, idx_in_reg} < 32'(high_reg)) && (32'(idx_in_reg) < SLOT_COUNT);
    assign live     = idx_ok && s_rdata[GEN_WIDTH]
                      && (32'(s_rdata[GEN_WIDTH-1:0]) == 32'(gen_in_reg));
    assign pend_slot  = p_rdata[IW+31:32];
    assign pend_frame = p_rdata[31:0];
    assign aged       = (frame_reg - pend_frame) >= 32'(age_limit);
    assign alloc_slot = (free_cnt_reg != '0) ? f_rdata : high_reg[IW-1:0];

    assign stat.clear_done = (clr_reg == FULL_CNT - CW'(1));
    assign stat.is_tick    = (mode_reg == gstdf_pkg::MODE_TICK);
    assign stat.scan_done  = (rd_reg == pend_cnt_reg);
    assign stat.retire     = aged;

    // memory addressing
    always_comb
    begin
        s_raddr = cmd.latch_req ? IW'(slot_index) : in_idx;
        s_we    = 1'b0;
        s_waddr = in_idx;
        s_wdata = s_rdata;
        f_raddr = free_cnt_reg[IW-1:0] - IW'(1);
        f_we    = 1'b0;
        f_waddr = free_cnt_reg[IW-1:0];
        f_wdata = pend_slot;
        // hold the entry under scan until the next read step
        p_raddr = cmd.tick_rd ? rd_reg[IW-1:0] : rd_reg[IW-1:0] - IW'(1);
        p_we    = 1'b0;
        p_waddr = pend_cnt_reg[IW-1:0];
        p_wdata = {in_idx, frame_reg};
        if (clearing)
        begin
            s_we    = 1'b1;
            s_waddr = clr_reg[IW-1:0];
            s_wdata = '0;
        end
        else if (cmd.exec)
        begin
            if (mode_reg == gstdf_pkg::MODE_ALLOC)
            begin
                s_raddr = alloc_slot;
            end
        end
        else if (cmd.look && mode_reg == gstdf_pkg::MODE_ALLOC)
        begin
            s_raddr = alloc_slot;
        end
        if (cmd.tick_do || cmd.tick_gen)
        begin
            s_raddr = pend_slot;
        end
        if (cmd.look && mode_reg == gstdf_pkg::MODE_DESTROY && live)
        begin
            s_we    = 1'b1;
            s_wdata = {1'b0, s_rdata[GEN_WIDTH-1:0]};
            p_we    = (pend_cnt_reg < FULL_CNT);
        end
        if (cmd.exec && mode_reg == gstdf_pkg::MODE_ALLOC && st_reg == gstdf_pkg::STATUS_OK)
        begin
            s_we    = 1'b1;
            s_waddr = oidx_reg;
            s_wdata = {1'b1, s_rdata[GEN_WIDTH-1:0]};
        end
        if (cmd.tick_do)
        begin
            if (!aged)
            begin
                p_we    = 1'b1;
                p_waddr = keep_reg[IW-1:0];
                p_wdata = p_rdata;
            end
            else if (free_cnt_reg < FULL_CNT)
            begin
                f_we = 1'b1;
            end
        end
        if (cmd.tick_gen)
        begin
            s_we    = 1'b1;
            s_waddr = pend_slot;
            s_wdata = {s_rdata[GEN_WIDTH], s_rdata[GEN_WIDTH-1:0] + GEN_WIDTH'(1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg     <= '0;
            free_cnt_reg <= '0;
            pend_cnt_reg <= '0;
            frame_reg    <= '0;
            clr_reg      <= '0;
            rd_reg       <= '0;
            keep_reg     <= '0;
            ret_reg      <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cmd.look && mode_reg == gstdf_pkg::MODE_ALLOC)
            begin
                if (free_cnt_reg != '0)
                begin
                    free_cnt_reg <= free_cnt_reg - CW'(1);
                end
                else if (high_reg < FULL_CNT)
                begin
                    high_reg <= high_reg + CW'(1);
                end
            end
            if (cmd.look && mode_reg == gstdf_pkg::MODE_DESTROY && live
                && pend_cnt_reg < FULL_CNT)
            begin
                pend_cnt_reg <= pend_cnt_reg + CW'(1);
            end
            if (cmd.tick_start)
            begin
                frame_reg <= frame_reg + 32'd1;
                rd_reg    <= '0;
                keep_reg  <= '0;
                ret_reg   <= '0;
            end
            if (cmd.tick_rd)
            begin
                rd_reg <= rd_reg + CW'(1);
            end
            if (cmd.tick_do)
            begin
                if (aged)
                begin
                    ret_reg <= ret_reg + CW'(1);
                    if (free_cnt_reg < FULL_CNT)
                    begin
                        free_cnt_reg <= free_cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    keep_reg <= keep_reg + CW'(1);
                end
            end
            if (cmd.out_load && mode_reg == gstdf_pkg::MODE_TICK)
            begin
                pend_cnt_reg <= keep_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            mode_reg   <= mode;
            idx_in_reg <= slot_index;
            gen_in_reg <= handle_generation;
        end
        if (cmd.look)
        begin
            st_reg   <= gstdf_pkg::STATUS_OK;
            oidx_reg <= '0;
            unique case (mode_reg)
                gstdf_pkg::MODE_ALLOC:
                begin
                    if (free_cnt_reg != '0)
                    begin
                        oidx_reg <= f_rdata;
                    end
                    else if (high_reg < FULL_CNT)
                    begin
                        oidx_reg <= high_reg[IW-1:0];
                    end
                    else
                    begin
                        st_reg <= gstdf_pkg::STATUS_FULL;
                    end
                end
                gstdf_pkg::MODE_DESTROY, gstdf_pkg::MODE_RESOLVE:
                    st_reg <= live ? gstdf_pkg::STATUS_OK : gstdf_pkg::STATUS_STALE;
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            status         <= st_reg;
            out_index      <= '0;
            out_generation <= '0;
            retired_count  <= '0;
            if (mode_reg == gstdf_pkg::MODE_ALLOC && st_reg == gstdf_pkg::STATUS_OK)
            begin
                out_index      <= 8'(oidx_reg);
                out_generation <= 16'(ogen_reg);
            end
            if (mode_reg == gstdf_pkg::MODE_TICK)
            begin
                status        <= gstdf_pkg::STATUS_OK;
                retired_count <= 9'(ret_reg);
            end
        end
        if (cmd.exec)
        begin
            ogen_reg <= s_rdata[GEN_WIDTH-1:0];
        end
    end

endmodule

[rtl/generational_slot_table_deferred_free.sv]
// Top level: generational slot table with deferred free.
// Allocate, destroy, resolve: after acceptance the request passes the look, execute and output states.
// Frame tick: each queued entry is read, waited on and processed, with a generation bump when it retires.
// One request at a time; the next is taken as the result register frees.
// After reset a clearing pass zeroes the state of every slot; no request is taken meanwhile.
// Reset is asynchronous, active low.
module generational_slot_table_deferred_free #(
    parameter int SLOT_COUNT = 256,
    parameter int GEN_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  slot_index,
    input  logic [15:0] handle_generation,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  out_index,
    output logic [15:0] out_generation,
    output logic [8:0]  retired_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gstdf_pkg::dp_cmd_t  cmd;
    gstdf_pkg::dp_stat_t stat;
    logic [3:0]          fif_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {28'd0, fif_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fif_reg <= gstdf_pkg::FIF_RESET;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            fif_reg <= pwdata[3:0];
        end
    end

    gstdf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd));

    gstdf_dp #(.SLOT_COUNT(SLOT_COUNT), .GEN_WIDTH(GEN_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .mode(mode),
        .slot_index(slot_index), .handle_generation(handle_generation),
        .age_limit(fif_reg), .status(status), .out_index(out_index),
        .out_generation(out_generation), .retired_count(retired_count));

endmodule

[rtl/gstdf_checker.sv]
// Port-level assertions for the slot table, bound to the top level.
module gstdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [8:0]  retired_count,
    input logic [15:0] out_generation
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("illegal status code");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == 2'd2 |-> out_generation == 16'd0 && retired_count == 9'd0)
        else $error("full result carries data");

endmodule

bind generational_slot_table_deferred_free gstdf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .retired_count(retired_count), .out_generation(out_generation));

[bench/generational_slot_table_deferred_free_test.sv]
// Testbench for the generational slot table: random handle traffic checked against a predictor.
module generational_slot_table_deferred_free_test;

    localparam int LIMIT = 20000000;

    typedef enum logic [1:0] {PICK_RAW, PICK_LIVE, PICK_STALE, PICK_DEAD} pick_t;

    typedef struct {
        logic [1:0]  mode;
        pick_t       pick;
        logic [7:0]  idx;
        logic [15:0] gen;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  idx;
        logic [15:0] gen;
        logic [8:0]  retired;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [7:0]  slot_index;
    logic [15:0] handle_generation;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  out_index;
    logic [15:0] out_generation;
    logic [8:0]  retired_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    generational_slot_table_deferred_free dut (.*);

    // slot table shadow
    logic [15:0] slot_gen[256];
    bit          slot_live[256];
    int          high_water;
    logic [7:0]  free_slots[256];
    int          free_cnt;
    logic [7:0]  pend_slot[256];
    logic [31:0] pend_frame[256];
    int          pend_cnt;
    logic [31:0] frame_ctr;
    logic [3:0]  fif;

    request_t request_q[$];
    result_t  expected_q[$];
    request_t cur;
    int       errors;
    int       cycles;
    int       burst_left;
    int       gap_left;
    int       stall_mode;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_t apply_request(request_t r);
        result_t res;
        bit      live;
        int      keep;
        logic [7:0] s;
        res = '{gstdf_pkg::STATUS_OK, 8'd0, 16'd0, 9'd0};
        live = r.idx < high_water && slot_live[r.idx] && slot_gen[r.idx] == r.gen;
        case (r.mode)
            gstdf_pkg::MODE_ALLOC:
            begin
                if (free_cnt > 0)
                begin
                    free_cnt--;
                    s = free_slots[free_cnt];
                end
                else if (high_water < 256)
                begin
                    s = high_water[7:0];
                    high_water++;
                end
                else
                begin
                    res.status = gstdf_pkg::STATUS_FULL;
                    return res;
                end
                slot_live[s] = 1'b1;
                res.idx = s;
                res.gen = slot_gen[s];
            end
            gstdf_pkg::MODE_DESTROY:
            begin
                if (live)
                begin
                    slot_live[r.idx] = 1'b0;
                    if (pend_cnt < 256)
                    begin
                        pend_slot[pend_cnt] = r.idx;
                        pend_frame[pend_cnt] = frame_ctr;
                        pend_cnt++;
                    end
                end
                else
                    res.status = gstdf_pkg::STATUS_STALE;
            end
            gstdf_pkg::MODE_RESOLVE:
                res.status = live ? gstdf_pkg::STATUS_OK : gstdf_pkg::STATUS_STALE;
            default:
            begin
                keep = 0;
                frame_ctr = frame_ctr + 32'd1;
                for (int i = 0; i < pend_cnt; i++)
                begin
                    if (frame_ctr - pend_frame[i] >= {28'd0, fif})
                    begin
                        slot_gen[pend_slot[i]] = slot_gen[pend_slot[i]] + 16'd1;
                        free_slots[free_cnt] = pend_slot[i];
                        free_cnt++;
                        res.retired++;
                    end
                    else
                    begin
                        pend_slot[keep] = pend_slot[i];
                        pend_frame[keep] = pend_frame[i];
                        keep++;
                    end
                end
                pend_cnt = keep;
            end
        endcase
        return res;
    endfunction

    // pick a slot with the wanted alive state among used slots; -1 if none
    function automatic int choose_slot(bit want_live);
        int n;
        int k;
        n = 0;
        for (int i = 0; i < high_water; i++)
            if (slot_live[i] == want_live)
                n++;
        if (n == 0)
            return -1;
        k = $urandom_range(n - 1);
        for (int i = 0; i < high_water; i++)
            if (slot_live[i] == want_live)
            begin
                if (k == 0)
                    return i;
                k--;
            end
        return -1;
    endfunction

    function automatic request_t bind_handle(request_t r);
        int s;
        if (r.pick == PICK_RAW)
            return r;
        s = choose_slot(r.pick != PICK_DEAD);
        if (s < 0)
            return r;
        r.idx = s[7:0];
        r.gen = slot_gen[s];
        if (r.pick == PICK_STALE)
            r.gen = r.gen ^ (16'd1 << $urandom_range(15));
        return r;
    endfunction

    // request side: bursts with gaps, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= gstdf_pkg::MODE_ALLOC;
            slot_index <= 8'd0;
            handle_generation <= 16'd0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_q.insert(expected_q.size(), apply_request(cur));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    cur = bind_handle(request_q.pop_front());
                    in_valid <= 1'b1;
                    mode <= cur.mode;
                    slot_index <= cur.idx;
                    handle_generation <= cur.gen;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side: the stall pattern is redrawn at random between always ready, random ready and sparse ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if (cycles % 64 == 0)
                stall_mode <= $urandom_range(2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(1));
                default: out_ready <= (cycles % 4 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d index %0d gen %0d retired %0d",
                             status, out_index, out_generation, retired_count);
            end
            else
            begin
                result_t e;
                e = expected_q.pop_front();
                if (status !== e.status || out_index !== e.idx ||
                    out_generation !== e.gen || retired_count !== e.retired)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 e.status, e.idx, e.gen, e.retired,
                                 status, out_index, out_generation, retired_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_fif(logic [3:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 1'b0;
        pwdata <= {28'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        fif = v;
    endtask

    task automatic queue_request(logic [1:0] m, pick_t p, logic [7:0] i, logic [15:0] g);
        request_t r;
        r.mode = m;
        r.pick = p;
        r.idx = i;
        r.gen = g;
        request_q.insert(request_q.size(), r);
    endtask

    // weights in percent; the remainder is random noise
    task automatic queue_phase(int n, int w_alloc, int w_destroy, int w_resolve, int w_tick);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < w_alloc)
                queue_request(gstdf_pkg::MODE_ALLOC, PICK_RAW, 8'($urandom), 16'($urandom));
            else if (r < w_alloc + w_destroy)
                queue_request(gstdf_pkg::MODE_DESTROY,
                              ($urandom_range(5) == 0) ? PICK_STALE : PICK_LIVE,
                              8'd0, 16'd0);
            else if (r < w_alloc + w_destroy + w_resolve)
                queue_request(gstdf_pkg::MODE_RESOLVE, pick_t'($urandom_range(1, 3)),
                              8'd0, 16'd0);
            else if (r < w_alloc + w_destroy + w_resolve + w_tick)
                queue_request(gstdf_pkg::MODE_TICK, PICK_RAW, 8'($urandom), 16'($urandom));
            else
                queue_request(2'($urandom), PICK_RAW, 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic drain;
        while (request_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        for (int i = 0; i < 256; i++)
        begin
            slot_gen[i] = 16'd0;
            slot_live[i] = 1'b0;
        end
        high_water = 0;
        free_cnt = 0;
        pend_cnt = 0;
        frame_ctr = 32'd0;
        fif = gstdf_pkg::FIF_RESET;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = 32'd0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset depth, unused index, live, stale, dead handles, ticks
        queue_request(gstdf_pkg::MODE_RESOLVE, PICK_RAW, 8'd255, 16'hFFFF);
        queue_request(gstdf_pkg::MODE_DESTROY, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_ALLOC, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_ALLOC, PICK_RAW, 8'hFF, 16'hFFFF);
        queue_request(gstdf_pkg::MODE_ALLOC, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_RESOLVE, PICK_LIVE, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_RESOLVE, PICK_STALE, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_DESTROY, PICK_STALE, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_DESTROY, PICK_LIVE, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_DESTROY, PICK_DEAD, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_RESOLVE, PICK_DEAD, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_DESTROY, PICK_RAW, 8'd200, 16'd0);
        queue_request(gstdf_pkg::MODE_TICK, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_ALLOC, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_TICK, PICK_RAW, 8'hFF, 16'hFFFF);
        queue_request(gstdf_pkg::MODE_ALLOC, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_DESTROY, PICK_LIVE, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_TICK, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_TICK, PICK_RAW, 8'd0, 16'd0);
        queue_request(gstdf_pkg::MODE_ALLOC, PICK_RAW, 8'd0, 16'd0);
        drain();

        write_fif(4'd1);
        queue_phase(250, 35, 25, 15, 15);
        drain();
        // fill the table until allocate reports full
        write_fif(4'd8);
        queue_phase(330, 80, 5, 10, 3);
        drain();
        queue_phase(300, 15, 35, 15, 30);
        drain();
        write_fif(4'd2);
        queue_phase(280, 30, 25, 20, 15);
        drain();
        write_fif(4'($urandom_range(1, 8)));
        queue_phase(280, 30, 30, 15, 15);
        drain();
        write_fif(4'($urandom_range(1, 8)));
        queue_phase(250, 30, 30, 15, 15);
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
